// ===== hdl/spr_pkg.sv =====
// Shared types and constants for the surface pool recycler.
// Item, result and pool entry layouts; opcodes, result kinds, register map.
// No dependencies.
package spr_pkg;

	localparam int CNT_W = 7;

	localparam logic [1:0] OP_FETCH   = 2'd0;
	localparam logic [1:0] OP_RECYCLE = 2'd1;
	localparam logic [1:0] OP_AGE     = 2'd2;
	localparam logic [1:0] OP_PURGE   = 2'd3;

	localparam logic [1:0] KIND_HIT   = 2'd0;
	localparam logic [1:0] KIND_MISS  = 2'd1;
	localparam logic [1:0] KIND_EVICT = 2'd2;
	localparam logic [1:0] KIND_DONE  = 2'd3;

	localparam logic REG_KEEP_MIN  = 1'b0;
	localparam logic REG_AGE_LIMIT = 1'b1;

	localparam logic [CNT_W-1:0] KEEP_MIN_RST  = 7'd40;
	localparam logic [15:0]      AGE_LIMIT_RST = 16'd10;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [15:0] handle_id;
		logic [2:0]  surface_type;
		logic [15:0] surface_format;
		logic [13:0] width;
		logic [13:0] height;
	} item_t;

	typedef struct packed {
		logic [1:0]       result_kind;
		logic [15:0]      result_handle;
		logic [CNT_W-1:0] pool_count;
		logic             last;
	} result_t;

	typedef struct packed {
		logic [15:0] handle;
		logic [2:0]  stype;
		logic [15:0] format;
		logic [13:0] width;
		logic [13:0] height;
		logic [31:0] stamp;
	} entry_t;

endpackage

// ===== hdl/surface_pool_recycler_top.sv =====
// Top level of the surface pool recycler: command sequencer, APB registers,
// result register. Depends on spr_pkg and instantiates spr_store.
//
//  Channel   Direction  Handshake              Beat
//  in        input      in_valid / in_ready    spr_pkg::item_t, one command
//  out       output     out_valid / out_ready  spr_pkg::result_t, one result
//  apb       input      psel/penable/pready    32-bit register access
//
// Commands run one at a time. A fetch reads and compares each entry searched
// (F_RD, F_CMP), then reads and writes each entry moved to close the gap
// (S_RD, S_WR). A recycle writes in R_WR; age tick and purge check each
// eviction (A_CHK, A_EVAL), paced by the entry memory's single read port.
// Reset clears count, frame counter and ring head and resets the registers to
// defaults; the memory needs no clearing as only entries below the count are read.
// A full result register stalls the sequencer; a new command is taken only
// when the previous one has handed its final beat to the result register.
module surface_pool_recycler_top #(
	parameter int POOL_DEPTH = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  spr_pkg::item_t    in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output spr_pkg::result_t  out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import spr_pkg::*;

	localparam int AW = $clog2(POOL_DEPTH);
	localparam logic [AW:0]      DEPTH_W = (AW+1)'(POOL_DEPTH);
	localparam logic [AW-1:0]    LAST_SLOT = AW'(POOL_DEPTH - 1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(POOL_DEPTH);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_F_RD   = 4'd1;
	localparam logic [3:0] ST_F_CMP  = 4'd2;
	localparam logic [3:0] ST_S_RD   = 4'd3;
	localparam logic [3:0] ST_S_WR   = 4'd4;
	localparam logic [3:0] ST_R_WR   = 4'd5;
	localparam logic [3:0] ST_A_CHK  = 4'd6;
	localparam logic [3:0] ST_A_EVAL = 4'd7;
	localparam logic [3:0] ST_END    = 4'd8;

	// Logical position (0 = newest) to physical slot in the ring.
	function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
			input logic [AW-1:0] pos);
		logic [AW:0] s;
		s = {1'b0, head} + {1'b0, pos};
		if (s >= DEPTH_W) begin
			s = s - DEPTH_W;
		end
		return s[AW-1:0];
	endfunction

	logic [3:0]       state_q;
	item_t            cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [31:0]      frame_q;
	logic [AW-1:0]    head_q;
	logic [AW-1:0]    idx_q;
	logic [CNT_W-1:0] keep_q;
	logic [15:0]      age_q;
	logic             pend_v_q;
	logic [1:0]       pend_kind_q;
	logic [15:0]      pend_handle_q;
	logic             out_valid_q;
	result_t          out_data_q;

	logic             we, re;
	logic [AW-1:0]    waddr, raddr;
	entry_t           wdata, rdata;

	logic             can_emit;
	logic             emit_beat;
	logic [CNT_W-1:0] cnt_m1;
	logic [AW-1:0]    oldest, head_inc, head_dec;
	logic             key_match, purge, old_enough, full;
	logic [31:0]      age_diff;

	spr_store #(.DEPTH(POOL_DEPTH)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign can_emit = !out_valid_q || out_ready;
	assign cnt_m1   = count_q - 1'b1;
	assign oldest   = phys(head_q, cnt_m1[AW-1:0]);
	assign head_inc = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
	assign full     = count_q >= DEPTH_C;
	assign purge    = cmd_q.opcode == OP_PURGE;
	assign age_diff = frame_q - rdata.stamp;
	assign old_enough = purge || (age_diff > {16'd0, age_q});
	assign key_match = rdata.stype == cmd_q.surface_type
		&& rdata.format == cmd_q.surface_format
		&& rdata.width == cmd_q.width && rdata.height == cmd_q.height;
	// A beat enters the result register on the final beat of a command or
	// when a further eviction pushes out the one held back.
	assign emit_beat = can_emit && ((state_q == ST_END)
		|| (state_q == ST_A_EVAL && old_enough && pend_v_q));

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign pready    = 1'b1;
	assign prdata    = (paddr[2] == REG_AGE_LIMIT) ? {16'd0, age_q}
		: {{(32-CNT_W){1'b0}}, keep_q};

	// Memory port control.
	always_comb begin
		re    = 1'b0;
		raddr = oldest;
		we    = 1'b0;
		waddr = head_dec;
		wdata = rdata;
		case (state_q)
			ST_IDLE: begin
				re = in_valid && in_data.opcode == OP_RECYCLE && full;
			end
			ST_F_RD: begin
				re    = 1'b1;
				raddr = phys(head_q, idx_q);
			end
			ST_S_RD: begin
				re    = 1'b1;
				raddr = phys(head_q, idx_q - 1'b1);
			end
			ST_S_WR: begin
				we    = 1'b1;
				waddr = phys(head_q, idx_q);
			end
			ST_R_WR: begin
				we    = 1'b1;
				wdata = '{handle: cmd_q.handle_id, stype: cmd_q.surface_type,
					format: cmd_q.surface_format, width: cmd_q.width,
					height: cmd_q.height, stamp: frame_q};
			end
			ST_A_CHK: begin
				re = count_q != '0 && (purge || count_q > keep_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			frame_q     <= '0;
			head_q      <= '0;
			keep_q      <= KEEP_MIN_RST;
			age_q       <= AGE_LIMIT_RST;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (psel && penable && pwrite) begin
				if (paddr[2] == REG_AGE_LIMIT) begin
					age_q <= pwdata[15:0];
				end else begin
					keep_q <= pwdata[CNT_W-1:0];
				end
			end
			if (emit_beat) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q    <= in_data;
						idx_q    <= '0;
						case (in_data.opcode)
							OP_FETCH: begin
								if (count_q == '0) begin
									pend_v_q      <= 1'b1;
									pend_kind_q   <= KIND_MISS;
									pend_handle_q <= '0;
									state_q       <= ST_END;
								end else begin
									state_q <= ST_F_RD;
								end
							end
							OP_RECYCLE: state_q <= ST_R_WR;
							OP_AGE: begin
								frame_q <= frame_q + 1'b1;
								state_q <= ST_A_CHK;
							end
							default: state_q <= ST_A_CHK;
						endcase
					end
				end
				ST_F_RD: state_q <= ST_F_CMP;
				ST_F_CMP: begin
					if (key_match) begin
						pend_v_q      <= 1'b1;
						pend_kind_q   <= KIND_HIT;
						pend_handle_q <= rdata.handle;
						if (idx_q == '0) begin
							head_q  <= head_inc;
							count_q <= cnt_m1;
							state_q <= ST_END;
						end else begin
							state_q <= ST_S_RD;
						end
					end else if ({1'b0, idx_q} == cnt_m1) begin
						pend_v_q      <= 1'b1;
						pend_kind_q   <= KIND_MISS;
						pend_handle_q <= '0;
						state_q       <= ST_END;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_F_RD;
					end
				end
				ST_S_RD: state_q <= ST_S_WR;
				ST_S_WR: begin
					// Newer entries slide one place toward the gap.
					if (idx_q == AW'(1)) begin
						head_q  <= head_inc;
						count_q <= cnt_m1;
						state_q <= ST_END;
					end else begin
						idx_q   <= idx_q - 1'b1;
						state_q <= ST_S_RD;
					end
				end
				ST_R_WR: begin
					head_q        <= head_dec;
					pend_v_q      <= 1'b1;
					pend_kind_q   <= full ? KIND_EVICT : KIND_DONE;
					pend_handle_q <= full ? rdata.handle : 16'd0;
					if (!full) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= ST_END;
				end
				ST_A_CHK: begin
					state_q <= re ? ST_A_EVAL : ST_END;
				end
				ST_A_EVAL: begin
					if (!old_enough) begin
						state_q <= ST_END;
					end else if (!pend_v_q || can_emit) begin
						// The previous eviction is not the last one.
						if (pend_v_q) begin
							out_data_q  <= '{result_kind: pend_kind_q,
								result_handle: pend_handle_q,
								pool_count: count_q, last: 1'b0};
						end
						pend_v_q      <= 1'b1;
						pend_kind_q   <= KIND_EVICT;
						pend_handle_q <= rdata.handle;
						count_q       <= cnt_m1;
						state_q       <= ST_A_CHK;
					end
				end
				ST_END: begin
					if (can_emit) begin
						out_data_q  <= '{result_kind: pend_v_q ? pend_kind_q : KIND_DONE,
							result_handle: pend_v_q ? pend_handle_q : 16'd0,
							pool_count: count_q, last: 1'b1};
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	// The sequencer never reads a slot in the cycle it writes it.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && waddr == raddr))
		else $error("read and write hit the same pool slot");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
		else $error("pool count above depth");

	a_end_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_END && can_emit) |=> state_q == ST_IDLE && out_valid_q
			&& out_data_q.last)
		else $error("final beat not issued");

	a_no_fetch_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_F_RD) |-> count_q != '0)
		else $error("search started on an empty pool");
`endif

endmodule

// ===== hdl/spr_store.sv =====
// Pool entry memory: one write port, one read port with registered data.
// Depends on spr_pkg for the entry layout.
module spr_store #(
	parameter int DEPTH = 64
) (
	input  logic                      clk,
	input  logic                      we,
	input  logic [$clog2(DEPTH)-1:0]  waddr,
	input  spr_pkg::entry_t           wdata,
	input  logic                      re,
	input  logic [$clog2(DEPTH)-1:0]  raddr,
	output spr_pkg::entry_t           rdata
);
	import spr_pkg::*;

	entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
